[sv/wdraw_pkg.sv]
// Package: shared types and codes for the weighted draw block.
`default_nettype none
package wdraw_pkg;
    localparam int FUNC_W   = 2;
    localparam int ID_W     = 32;
    localparam int WEIGHT_W = 16;
    localparam int FRAC_W   = 32;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 10;
    localparam int SUM_W    = 25;
    localparam int WT_W     = 15;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DRAW   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DRAWN    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [ID_W-1:0]     item_id;
        logic [WEIGHT_W-1:0] weight;
        logic [FRAC_W-1:0]   rand_fraction;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     picked_id;
        logic [POS_W-1:0]    picked_index;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_MUL, S_SRCH, S_SRCH_W, S_SEED, S_WALK_RD, S_WALK,
        S_UPD_RD, S_UPD_WR, S_DONE, S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic do_clear;
        logic do_append;
        logic mul;
        logic srch_start;
        logic srch_rd;
        logic srch_step;
        logic seed;
        logic walk_rd;
        logic walk_step;
        logic upd_start;
        logic upd_rd;
        logic upd_wr;
        logic finish_draw;
        logic set_empty;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic empty;
        logic srch_done;
        logic walk_done;
        logic upd_done;
    } stat_t;
endpackage
`default_nettype wire

[sv/wdraw_if.sv]
// Interface: valid/ready request channel with payload.
`default_nettype none
interface wdraw_if #(parameter type payload_t = logic) (input wire logic clk);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/wdraw_ctrl.sv]
// Controller: sequences clear, append and draw over the datapath.
`default_nettype none
module wdraw_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire wdraw_pkg::stat_t stat,
    output wdraw_pkg::cmd_t      cmd
);
    import wdraw_pkg::*;
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == S_IDLE);
        out_valid  = (state_reg == S_OUT);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.func)
                    FUNC_CLEAR:
                    begin
                        cmd.do_clear = 1'b1;
                        state_next   = S_OUT;
                    end
                    FUNC_APPEND:
                    begin
                        cmd.do_append = 1'b1;
                        state_next    = S_OUT;
                    end
                    FUNC_DRAW:
                    begin
                        if (stat.empty)
                        begin
                            cmd.set_empty = 1'b1;
                            state_next    = S_OUT;
                        end
                        else
                        begin
                            cmd.mul    = 1'b1;
                            state_next = S_MUL;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_MUL:
            begin
                cmd.srch_start = 1'b1;
                state_next     = S_SRCH;
            end
            S_SRCH:
            begin
                if (stat.srch_done)
                begin
                    cmd.seed   = 1'b1;
                    state_next = S_SEED;
                end
                else
                begin
                    cmd.srch_rd = 1'b1;
                    state_next  = S_SRCH_W;
                end
            end
            S_SRCH_W:
            begin
                cmd.srch_step = 1'b1;
                state_next    = S_SRCH;
            end
            S_SEED:
            begin
                cmd.walk_rd = 1'b1;
                state_next  = S_WALK_RD;
            end
            S_WALK_RD: state_next = S_WALK;
            S_WALK:
            begin
                if (stat.walk_done)
                begin
                    cmd.upd_start = 1'b1;
                    state_next    = S_UPD_RD;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                    cmd.walk_rd   = 1'b1;
                    state_next    = S_WALK_RD;
                end
            end
            S_UPD_RD:
            begin
                if (stat.upd_done)
                begin
                    cmd.finish_draw = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.upd_rd = 1'b1;
                    state_next = S_UPD_WR;
                end
            end
            S_UPD_WR:
            begin
                cmd.upd_wr = 1'b1;
                state_next = S_UPD_RD;
            end
            S_DONE: state_next = S_OUT;
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

[sv/wdraw_dp.sv]
// Datapath: weight/id tables, prefix index, total, search and walk registers.
`default_nettype none
module wdraw_dp #(
    parameter int MAX_ITEMS      = 1024,
    parameter int INDEX_INTERVAL = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire wdraw_pkg::req_t  req,
    input  wire wdraw_pkg::cmd_t  cmd,
    output wdraw_pkg::stat_t      stat,
    output wdraw_pkg::rsp_t       rsp
);
    import wdraw_pkg::*;
    localparam int IDX_DEPTH = (MAX_ITEMS + INDEX_INTERVAL - 1) / INDEX_INTERVAL;
    localparam int AW  = $clog2(MAX_ITEMS);
    localparam int IW  = (IDX_DEPTH > 1) ? $clog2(IDX_DEPTH) : 1;
    localparam int CW  = AW + 1;
    localparam int EW  = IW + 1;
    localparam int PW  = (INDEX_INTERVAL > 1) ? $clog2(INDEX_INTERVAL) : 1;

    logic [WT_W-1:0]  wmem [MAX_ITEMS];
    logic [ID_W-1:0]  idmem [MAX_ITEMS];
    logic [SUM_W-1:0] pmem [IDX_DEPTH];

    req_t             req_reg;
    rsp_t             rsp_reg;
    logic [SUM_W-1:0] total_reg;
    logic [CW-1:0]    count_reg;
    logic [PW-1:0]    cph_reg;
    logic [EW-1:0]    cent_reg;
    logic [SUM_W-1:0] value_reg;
    logic [EW-1:0]    lo_reg, hi_reg, ent_reg, j_reg;
    logic [AW-1:0]    pos_reg;
    logic [PW-1:0]    wph_reg;
    logic [EW-1:0]    whk_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [WT_W-1:0]  wrd_reg;
    logic [SUM_W-1:0] prd_reg;
    logic [ID_W-1:0]  idrd_reg;
    logic [WT_W-1:0]  wpick_reg;
    logic             state_seed_q;

    logic [FRAC_W+SUM_W-1:0] prod;
    logic [EW-1:0]           mid;
    logic [SUM_W-1:0]        prior_sum;
    logic [WT_W-1:0]         wpos;
    logic                    wpositive;
    logic [PW-1:0]           last_ph;
    logic [PW-1:0]           step_ph;

    assign prod      = (FRAC_W+SUM_W)'(req_reg.rand_fraction) * (FRAC_W+SUM_W)'(total_reg);
    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign prior_sum = (sum_reg >= SUM_W'(wrd_reg)) ? sum_reg - SUM_W'(wrd_reg) : '0;
    assign wpositive = !req_reg.weight[WEIGHT_W-1] && (req_reg.weight != '0);
    assign wpos      = req_reg.weight[WT_W-1:0];
    // position within its index interval of the last item and of the item before pos
    assign last_ph   = (cph_reg == '0) ? PW'(INDEX_INTERVAL - 1) : cph_reg - PW'(1);
    assign step_ph   = (wph_reg == '0) ? PW'(INDEX_INTERVAL - 1) : wph_reg - PW'(1);

    assign stat.func      = req_reg.func;
    assign stat.empty     = (total_reg == '0) || (count_reg == '0);
    assign stat.srch_done = (lo_reg >= hi_reg);
    assign stat.walk_done = (prior_sum <= value_reg) || (pos_reg == '0);
    assign stat.upd_done  = (j_reg >= ent_reg);
    assign rsp            = rsp_reg;

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.do_append && wpositive && (count_reg < CW'(MAX_ITEMS)))
        begin
            wmem[count_reg[AW-1:0]]  <= wpos;
            idmem[count_reg[AW-1:0]] <= req_reg.item_id;
        end
        else if (cmd.finish_draw)
            wmem[pos_reg] <= '0;
        if (cmd.walk_rd)
        begin
            wrd_reg  <= wmem[cmd.walk_step ? pos_reg - AW'(1) : pos_reg];
            idrd_reg <= idmem[cmd.walk_step ? pos_reg - AW'(1) : pos_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_append && wpositive && (count_reg < CW'(MAX_ITEMS))
            && (cph_reg == '0))
            pmem[cent_reg[IW-1:0]] <= total_reg + SUM_W'(wpos);
        else if (cmd.upd_wr)
            pmem[j_reg[IW-1:0]] <= (prd_reg >= SUM_W'(wpick_reg))
                                   ? prd_reg - SUM_W'(wpick_reg) : '0;
        if (cmd.srch_rd)
            prd_reg <= pmem[mid[IW-1:0]];
        else if (cmd.upd_rd)
            prd_reg <= pmem[j_reg[IW-1:0]];
        else if (cmd.seed && (lo_reg < ent_reg))
            prd_reg <= pmem[lo_reg[IW-1:0]];
    end

    // count, its phase within the interval and the number of index entries in use
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            count_reg <= '0;
            cph_reg   <= '0;
            cent_reg  <= '0;
        end
        else if (cmd.do_clear)
        begin
            total_reg <= '0;
            count_reg <= '0;
            cph_reg   <= '0;
            cent_reg  <= '0;
        end
        else if (cmd.do_append && wpositive && (count_reg < CW'(MAX_ITEMS)))
        begin
            total_reg <= total_reg + SUM_W'(wpos);
            count_reg <= count_reg + CW'(1);
            cph_reg   <= (cph_reg == PW'(INDEX_INTERVAL - 1)) ? '0 : cph_reg + PW'(1);
            if (cph_reg == '0)
                cent_reg <= cent_reg + EW'(1);
        end
        else if (cmd.finish_draw)
            total_reg <= (total_reg >= SUM_W'(wpick_reg)) ? total_reg - SUM_W'(wpick_reg) : '0;
    end

    // marks the walk read issued straight after seeding
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_seed_q <= 1'b0;
        else
            state_seed_q <= cmd.seed;
    end

    // search, walk and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= req;
        if (cmd.mul)
            value_reg <= prod[FRAC_W +: SUM_W];
        if (cmd.srch_start)
        begin
            lo_reg  <= '0;
            ent_reg <= cent_reg;
            hi_reg  <= cent_reg;
        end
        if (cmd.srch_step)
        begin
            if (prd_reg > value_reg)
                hi_reg <= mid;
            else
                lo_reg <= mid + EW'(1);
        end
        // whk_reg tracks the first index entry at or after pos
        if (cmd.seed)
        begin
            if (lo_reg >= ent_reg)
            begin
                pos_reg <= AW'(count_reg - CW'(1));
                sum_reg <= total_reg;
                wph_reg <= last_ph;
                whk_reg <= (last_ph == '0) ? cent_reg - EW'(1) : cent_reg;
            end
            else
            begin
                pos_reg <= AW'(lo_reg * INDEX_INTERVAL);
                sum_reg <= '0;
                wph_reg <= '0;
                whk_reg <= lo_reg;
            end
        end
        if (cmd.walk_rd && !cmd.walk_step && (state_seed_q))
            sum_reg <= (lo_reg >= ent_reg) ? total_reg : prd_reg;
        if (cmd.walk_step)
        begin
            sum_reg <= prior_sum;
            pos_reg <= pos_reg - AW'(1);
            wph_reg <= step_ph;
            whk_reg <= (step_ph == '0) ? whk_reg - EW'(1) : whk_reg;
        end
        if (cmd.upd_start)
        begin
            wpick_reg <= wrd_reg;
            j_reg     <= whk_reg;
        end
        if (cmd.upd_wr)
            j_reg <= j_reg + EW'(1);
        if (cmd.do_clear)
            rsp_reg <= '{ST_CLEARED, '0, '0};
        if (cmd.set_empty)
            rsp_reg <= '{ST_EMPTY, '0, '0};
        if (cmd.do_append)
        begin
            if (!wpositive)
                rsp_reg <= '{ST_DROPPED, '0, '0};
            else if (count_reg >= CW'(MAX_ITEMS))
                rsp_reg <= '{ST_FULL, '0, '0};
            else
                rsp_reg <= '{ST_APPENDED, '0, POS_W'(count_reg)};
        end
        if (cmd.finish_draw)
            rsp_reg <= '{ST_DRAWN, idrd_reg, POS_W'(pos_reg)};
    end
endmodule
`default_nettype wire

[sv/weighted_draw_without_replacement.sv]
// Top level: weighted draw without replacement over an appendable weight table.
//  channel | dir | payload
//  req     | in  | func, item_id, weight, rand_fraction
//  rsp     | out | status, picked_id, picked_index
// A draw scales rand_fraction by the total, binary-searches the prefix index, walks back
// over the items and then updates the later index entries. One request at a time.
// Reset (rst_n, async low) empties the table; the result holds until taken.
`default_nettype none
module weighted_draw_without_replacement #(
    parameter int MAX_ITEMS      = 1024,
    parameter int INDEX_INTERVAL = 16
) (
    input wire logic clk,
    input wire logic rst_n,
    wdraw_if.sink    req,
    wdraw_if.source  rsp
);
    import wdraw_pkg::*;
    cmd_t  cmd;
    stat_t stat;
    rsp_t  rsp_data;

    wdraw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    wdraw_dp #(
        .MAX_ITEMS      (MAX_ITEMS),
        .INDEX_INTERVAL (INDEX_INTERVAL)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.data),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp_data)
    );

    assign rsp.data = rsp_data;
endmodule
`default_nettype wire

[sv/wdraw_checker.sv]
// Checker: port-level properties of the weighted draw block, bound to the top.
`default_nettype none
module wdraw_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire logic [2:0] rsp_status,
    input wire logic [31:0] rsp_id
);
    import wdraw_pkg::*;
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready) else $error("request taken while result pending");
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
        else $error("result dropped under stall");
    a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_DRAWN |-> rsp_id == '0)
        else $error("id set on non-draw result");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_status <= ST_CLEARED) else $error("bad status");
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !rsp_valid) else $error("result too early");
endmodule

bind weighted_draw_without_replacement wdraw_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.data.status),
    .rsp_id     (rsp.data.picked_id)
);
`default_nettype wire

[tb/tb.sv]
// Testbench: random and directed requests against a predictor of the weighted draw block.
`default_nettype none
module tb;
    import wdraw_pkg::*;

    localparam int TABLE_SIZE = 1024;
    localparam int INTERVAL   = 16;
    localparam int LIMIT      = 3000000;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    logic clk;
    logic rst_n;

    wdraw_if #(.payload_t(req_t)) req_if (clk);
    wdraw_if #(.payload_t(rsp_t)) rsp_if (clk);

    weighted_draw_without_replacement #(
        .MAX_ITEMS      (TABLE_SIZE),
        .INDEX_INTERVAL (INTERVAL)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // predictor state
    logic [WT_W-1:0]  wt_tab [TABLE_SIZE];
    logic [ID_W-1:0]  id_tab [TABLE_SIZE];
    logic [SUM_W-1:0] pfx_sum [TABLE_SIZE/INTERVAL];
    logic [SUM_W-1:0] total_wt = '0;
    int               n_items = 0;

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    int   errors = 0;
    int   req_gap = 0;
    int   rsp_stall = 0;
    int   hold_left = 0;
    bit   hold_trigger = 1'b0;
    bit   hold_done = 1'b0;
    bit   calm = 1'b0;
    int   cycles = 0;
    int   random_reqs = 0;

    function automatic bit predict_rsp(input req_t r, output rsp_t e);
        logic signed [WEIGHT_W-1:0] w;
        longint unsigned prod;
        int value, entries, lo, hi, mid, pos, sum, prior, wsel;
        e = '0;
        case (r.func)
            FUNC_CLEAR:
            begin
                n_items = 0;
                total_wt = '0;
                e.status = ST_CLEARED;
            end
            FUNC_APPEND:
            begin
                w = r.weight;
                if (w <= 0)
                    e.status = ST_DROPPED;
                else if (n_items >= TABLE_SIZE)
                    e.status = ST_FULL;
                else
                begin
                    wt_tab[n_items] = w[WT_W-1:0];
                    id_tab[n_items] = r.item_id;
                    total_wt = total_wt + w[WT_W-1:0];
                    if (n_items % INTERVAL == 0)
                        pfx_sum[n_items / INTERVAL] = total_wt;
                    e.status = ST_APPENDED;
                    e.picked_index = n_items[POS_W-1:0];
                    n_items++;
                end
            end
            FUNC_DRAW:
            begin
                if (total_wt == 0 || n_items == 0)
                    e.status = ST_EMPTY;
                else
                begin
                    prod = longint'(r.rand_fraction) * longint'(total_wt);
                    value = int'(prod >> 32);
                    entries = (n_items + INTERVAL - 1) / INTERVAL;
                    lo = 0;
                    hi = entries;
                    while (lo < hi)
                    begin
                        mid = lo + (hi - lo) / 2;
                        if (int'(pfx_sum[mid]) > value)
                            hi = mid;
                        else
                            lo = mid + 1;
                    end
                    if (lo >= entries)
                    begin
                        pos = n_items - 1;
                        sum = total_wt;
                    end
                    else
                    begin
                        pos = lo * INTERVAL;
                        sum = pfx_sum[lo];
                    end
                    forever
                    begin
                        prior = (sum >= wt_tab[pos]) ? sum - wt_tab[pos] : 0;
                        if (prior <= value || pos == 0)
                            break;
                        sum = prior;
                        pos--;
                    end
                    wsel = wt_tab[pos];
                    for (int j = (pos + INTERVAL - 1) / INTERVAL; j < entries; j++)
                        pfx_sum[j] = (pfx_sum[j] >= wsel) ? pfx_sum[j] - wsel : '0;
                    total_wt = (total_wt >= wsel) ? total_wt - wsel : '0;
                    wt_tab[pos] = '0;
                    e.status = ST_DRAWN;
                    e.picked_id = id_tab[pos];
                    e.picked_index = pos[POS_W-1:0];
                end
            end
            default:
                return 0;
        endcase
        return 1;
    endfunction

    task automatic push_req(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] id,
                            input logic [WEIGHT_W-1:0] w, input logic [FRAC_W-1:0] fr);
        req_t r;
        r.func = f;
        r.item_id = id;
        r.weight = w;
        r.rand_fraction = fr;
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        if ($urandom_range(0, 9) == 0)
            return WEIGHT_W'($urandom);
        if ($urandom_range(0, 3) == 0)
            return WEIGHT_W'($urandom_range(1, 32767));
        return WEIGHT_W'($urandom_range(1, 600));
    endfunction

    task automatic push_batch(input int n_app, input int n_draw);
        int a, d;
        a = 0;
        d = 0;
        push_req(FUNC_CLEAR, $urandom, WEIGHT_W'($urandom), $urandom);
        random_reqs++;
        while (a < n_app || d < n_draw)
        begin
            if (a < n_app && (d >= n_draw || a == 0 || $urandom_range(0, 2) != 0))
            begin
                push_req(FUNC_APPEND, $urandom, pick_weight(), $urandom);
                a++;
            end
            else
            begin
                push_req(FUNC_DRAW, $urandom, WEIGHT_W'($urandom), $urandom);
                d++;
            end
            random_reqs++;
            if ($urandom_range(0, 49) == 0)
                push_req(FUNC_UNUSED, $urandom, WEIGHT_W'($urandom), $urandom);
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        fork
            forever #1 clk = ~clk;
        join_none
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        rst_n_dummy_guard:
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            req_if.data <= '0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                rsp_t e;
                if (predict_rsp(req_if.data, e))
                    expected_rsps.insert(expected_rsps.size(), e);
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (req_gap > 0)
                begin
                    req_gap <= req_gap - 1;
                    req_if.valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    req_if.data <= pending_reqs.pop_front();
                    req_if.valid <= 1'b1;
                    if (calm || $urandom_range(0, 9) < 6)
                        req_gap <= 0;
                    else if ($urandom_range(0, 9) < 8)
                        req_gap <= $urandom_range(1, 3);
                    else
                        req_gap <= $urandom_range(10, 40);
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result %p", $time, rsp_if.data);
                end
                else
                begin
                    rsp_t e;
                    e = expected_rsps.pop_front();
                    if (rsp_if.data.status !== e.status)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.status, rsp_if.data.status);
                    end
                    if (rsp_if.data.picked_id !== e.picked_id)
                    begin
                        errors++;
                        $display("%0t: picked_id expected %h actual %h",
                                 $time, e.picked_id, rsp_if.data.picked_id);
                    end
                    if (rsp_if.data.picked_index !== e.picked_index)
                    begin
                        errors++;
                        $display("%0t: picked_index expected %0d actual %0d",
                                 $time, e.picked_index, rsp_if.data.picked_index);
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                rsp_if.ready <= 1'b0;
            end
            else if (hold_trigger && !hold_done)
            begin
                hold_done <= 1'b1;
                hold_left <= 400;
                rsp_if.ready <= 1'b0;
            end
            else if (rsp_stall > 0)
            begin
                rsp_stall <= rsp_stall - 1;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                if (!calm)
                begin
                    if ($urandom_range(0, 99) < 20)
                        rsp_stall <= $urandom_range(1, 3);
                    else if ($urandom_range(0, 99) < 3)
                        rsp_stall <= $urandom_range(20, 60);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin
        int n;
        @(posedge rst_n);
        // empty table, weight edge cases, id extremes, wheel ends
        push_req(FUNC_DRAW, 32'h0, 16'h0, 32'hFFFF_FFFF);
        push_req(FUNC_APPEND, 32'h1234, 16'h0000, 32'h0);
        push_req(FUNC_APPEND, 32'h1234, 16'h8000, 32'h0);
        push_req(FUNC_APPEND, 32'h1234, 16'hFFFF, 32'h0);
        push_req(FUNC_APPEND, 32'h0000_0000, 16'h0001, 32'h0);
        push_req(FUNC_APPEND, 32'hFFFF_FFFF, 16'h7FFF, 32'h0);
        push_req(FUNC_APPEND, 32'hA5A5_5A5A, 16'h0100, 32'h0);
        push_req(FUNC_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        push_req(FUNC_DRAW, 32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0000);
        push_req(FUNC_DRAW, 32'h0, 16'h0, 32'hFFFF_FFFF);
        push_req(FUNC_DRAW, 32'h0, 16'h0, 32'h8000_0000);
        push_req(FUNC_DRAW, 32'h0, 16'h0, 32'h0);
        push_req(FUNC_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        push_req(FUNC_DRAW, 32'h0, 16'h0, 32'h0);
        for (int i = 0; i < 18; i++)
            push_req(FUNC_APPEND, ID_W'(i), WEIGHT_W'(i + 1), 32'h0);
        push_req(FUNC_DRAW, 32'h0, 16'h0, 32'h0000_0000);
        push_req(FUNC_DRAW, 32'h0, 16'h0, 32'hFFFF_FFFF);
        push_req(FUNC_DRAW, 32'h0, 16'h0, 32'h7000_0000);
        // sender pauses until every result is back
        wait_drained();

        while (random_reqs < 1250)
        begin
            calm = ($urandom_range(0, 4) == 0);
            if (random_reqs == 0)
            begin
                push_batch(TABLE_SIZE, 6);
                push_req(FUNC_APPEND, $urandom, 16'h0000, $urandom);
                push_req(FUNC_APPEND, $urandom, 16'h0040, $urandom);
                random_reqs += 2;
                hold_trigger = 1'b1;
            end
            else
            begin
                n = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 24);
                push_batch(n, $urandom_range(1, n + 3));
            end
            wait_drained();
        end

        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
`default_nettype wire
